// File: design/assert_macros.svh
// Assertion helpers used by lctar_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lctar_pkg.sv
package lctar_pkg;

  localparam int ALIAS_CHARS  = 32;
  localparam int SLOT_COUNT   = 2;
  localparam int CTX_AW       = $clog2(SLOT_COUNT);
  localparam int STORE_DEPTH  = SLOT_COUNT * ALIAS_CHARS;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int PAYLOAD_BITS = 56;

  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 128;
  localparam int M_TUSER_W = 5;

  localparam logic [7:0] PREV_NONE     = 8'hFF;
  localparam logic [7:0] MIN_BLOCK_LEN = 8'd9;
  localparam logic [3:0] CHAR_7BIT     = 4'd7;
  localparam logic [3:0] CHAR_8BIT     = 4'd8;

  localparam logic [5:0] OP_GROUP     = 6'd0;
  localparam logic [5:0] OP_PRIVATE   = 6'd3;
  localparam logic [5:0] OP_TA_HEADER = 6'd4;
  localparam logic [5:0] OP_TA_LAST   = 6'd7;

  localparam logic [1:0] FMT_7BIT        = 2'd0;
  localparam logic [1:0] FMT_UNSUPPORTED = 2'd3;

  typedef enum logic [2:0] {
    KIND_GROUP       = 3'd0,
    KIND_PRIVATE     = 3'd1,
    KIND_ALIAS       = 3'd2,
    KIND_UNSUPPORTED = 3'd3,
    KIND_INCOMPLETE  = 3'd4,
    KIND_RAW         = 3'd5
  } kind_t;

  typedef struct packed {
    logic        mode;
    logic        timeslot;
    logic [7:0]  block_length;
    logic [5:0]  opcode;
    logic [7:0]  feature_id;
    logic [55:0] payload;
  } in_item_t;

  // Per-slot alias context, one memory word per slot
  typedef struct packed {
    logic [7:0] prev;
    logic [1:0] fmt;
    logic [3:0] bpc;
    logic [7:0] rem;
    logic [4:0] cnt;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{prev: PREV_NONE, fmt: 2'd0, bpc: 4'd0, rem: 8'd0, cnt: 5'd0};

  typedef struct packed {
    kind_t       kind;
    logic        ended;
    logic        slot;
    logic [23:0] source_id;
    logic [23:0] target_id;
    logic [7:0]  alias_char;
    logic [1:0]  alias_format;
    logic        last;
    logic [5:0]  raw_opcode;
    logic [7:0]  raw_feature;
    logic [55:0] raw_payload;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// File: design/lctar_ram.sv
module lctar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/lctar_outreg.sv
module lctar_outreg (
  input  logic                             clk,
  input  logic                             rst,
  input  lctar_pkg::push_t                 push,
  output logic                             push_free,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [lctar_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [lctar_pkg::M_TUSER_W-1:0]  m_tuser,
  output logic                             m_tlast
);

  logic            full;
  lctar_pkg::res_t held;

  assign push_free = !full || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push.valid) begin
      full <= 1'b1;
    end else if (m_tready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      held <= push.res;
    end
  end

  assign m_tvalid = full;
  assign m_tdata  = {held.raw_payload, held.raw_feature, held.raw_opcode, held.alias_format,
                     held.alias_char, held.target_id, held.source_id};
  assign m_tuser  = {held.slot, held.ended, held.kind};
  assign m_tlast  = held.last;

endmodule

// File: design/lctar_ctrl.sv
`include "assert_macros.svh"

module lctar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lctar_pkg::in_item_t in_item,
  output lctar_pkg::push_t    push,
  input  logic                push_free
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CTX     = 7'b0000010,
    S_GATHER  = 7'b0000100,
    S_FINISH  = 7'b0001000,
    S_SINGLE  = 7'b0010000,
    S_EMIT_RD = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  localparam int SAW = lctar_pkg::STORE_AW;

  state_t state, state_next;

  lctar_pkg::in_item_t item;
  logic [lctar_pkg::SLOT_COUNT-1:0] ctx_valid;

  // Working copy of the slot context
  logic [7:0]  prev;
  logic [1:0]  fmt;
  logic [3:0]  bpc;
  logic [7:0]  rem;
  logic [4:0]  cnt;
  logic [5:0]  pos;
  logic [55:0] work;
  logic        gath;
  logic        fmt3;
  logic [4:0]  k;

  logic                             ctx_re, ctx_we;
  lctar_pkg::ctx_t                  ctx_rdata, ctx_wdata, ctx_cur;
  logic                             store_we, store_re;
  logic [SAW-1:0]                   store_waddr, store_raddr;
  logic [7:0]                       store_wdata, store_rdata;

  logic        is_call, is_short, is_talker, in_order, step, done, k_last;
  logic [1:0]  hfmt;
  logic [4:0]  hcnt;
  logic [7:0]  op8, h7, h8;
  logic [7:0]  char_val;
  lctar_pkg::res_t single_res, char_res;

  lctar_ram #(.WIDTH($bits(lctar_pkg::ctx_t)), .DEPTH(lctar_pkg::SLOT_COUNT)) u_ctx_ram (
    .clk  (clk),
    .we   (ctx_we),
    .waddr(item.timeslot),
    .wdata(ctx_wdata),
    .re   (ctx_re),
    .raddr(in_item.timeslot),
    .rdata(ctx_rdata)
  );

  lctar_ram #(.WIDTH(8), .DEPTH(lctar_pkg::STORE_DEPTH)) u_store_ram (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .re   (store_re),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  function automatic logic [SAW-1:0] store_addr(input logic slot, input logic [4:0] idx);
    store_addr = SAW'(slot) * SAW'(lctar_pkg::ALIAS_CHARS) + SAW'(idx);
  endfunction

  always_comb begin
    ctx_cur   = ctx_valid[item.timeslot] ? ctx_rdata : lctar_pkg::CTX_RESET;
    hfmt      = item.payload[55:54];
    hcnt      = item.payload[53:49];
    op8       = {2'b00, item.opcode};
    h7        = ({3'b000, hcnt} << 3) - {3'b000, hcnt};
    h8        = {hcnt, 3'b000};
    is_short  = item.block_length < lctar_pkg::MIN_BLOCK_LEN;
    is_call   = (item.opcode == lctar_pkg::OP_GROUP) || (item.opcode == lctar_pkg::OP_PRIVATE);
    is_talker = !is_short && !is_call && !item.mode &&
                (item.opcode >= lctar_pkg::OP_TA_HEADER) && (item.opcode <= lctar_pkg::OP_TA_LAST);
    in_order  = ({1'b0, ctx_cur.prev} + 9'd1) == {3'b000, item.opcode};
    step      = gath && (rem >= {4'b0000, bpc}) &&
                (({1'b0, pos} + {3'b000, bpc}) <= 7'(lctar_pkg::PAYLOAD_BITS));
    done      = (rem == 8'd0) && (cnt != 5'd0);
    char_val  = (bpc == lctar_pkg::CHAR_7BIT) ? {1'b0, work[55:49]} : work[55:48];
    k_last    = k == (cnt - 5'd1);
  end

  // Results: single-result items (short block, call info, unsupported format, raw) and alias characters
  always_comb begin
    single_res      = '0;
    single_res.slot = item.timeslot;
    single_res.last = 1'b1;
    if (is_short) begin
      single_res.kind = lctar_pkg::KIND_INCOMPLETE;
    end else if (is_call) begin
      single_res.kind      = (item.opcode == lctar_pkg::OP_GROUP) ?
                             lctar_pkg::KIND_GROUP : lctar_pkg::KIND_PRIVATE;
      single_res.ended     = item.mode;
      single_res.source_id = item.payload[23:0];
      single_res.target_id = item.payload[47:24];
    end else if (fmt3) begin
      single_res.kind         = lctar_pkg::KIND_UNSUPPORTED;
      single_res.alias_format = lctar_pkg::FMT_UNSUPPORTED;
    end else begin
      single_res.kind        = lctar_pkg::KIND_RAW;
      single_res.raw_opcode  = item.opcode;
      single_res.raw_feature = item.feature_id;
      single_res.raw_payload = item.payload;
    end

    char_res              = '0;
    char_res.kind         = lctar_pkg::KIND_ALIAS;
    char_res.slot         = item.timeslot;
    char_res.alias_char   = store_rdata;
    char_res.alias_format = fmt;
    char_res.last         = k_last;
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctx_re      = 1'b0;
    ctx_we      = 1'b0;
    ctx_wdata   = '{prev: prev, fmt: fmt, bpc: bpc, rem: rem, cnt: cnt};
    store_we    = 1'b0;
    store_waddr = store_addr(item.timeslot, cnt);
    store_wdata = char_val;
    store_re    = 1'b0;
    store_raddr = store_addr(item.timeslot, k);
    push.valid  = 1'b0;
    push.res    = single_res;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctx_re   = in_valid;
        if (in_valid) begin
          state_next = S_CTX;
        end
      end
      S_CTX: begin
        state_next = is_talker ? S_GATHER : S_SINGLE;
      end
      S_GATHER: begin
        store_we = step;
        if (!step) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        ctx_we = 1'b1;
        if (done) begin
          // Completed alias: release the slot for the next header
          ctx_wdata.prev = lctar_pkg::PREV_NONE;
          ctx_wdata.cnt  = 5'd0;
          state_next     = S_EMIT_RD;
        end else if (fmt3) begin
          state_next = S_SINGLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SINGLE: begin
        push.valid = push_free;
        if (push_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        store_re   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        push.valid  = push_free;
        push.res    = char_res;
        store_raddr = store_addr(item.timeslot, k + 5'd1);
        if (push_free) begin
          if (k_last) begin
            state_next = S_IDLE;
          end else begin
            store_re = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ctx_valid <= '0;
    end else begin
      state <= state_next;
      if (ctx_we) begin
        ctx_valid[item.timeslot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          item <= in_item;
          fmt3 <= 1'b0;
        end
      end
      S_CTX: begin
        prev <= ctx_cur.prev;
        fmt  <= ctx_cur.fmt;
        bpc  <= ctx_cur.bpc;
        rem  <= ctx_cur.rem;
        cnt  <= ctx_cur.cnt;
        gath <= 1'b0;
        pos  <= 6'd0;
        work <= item.payload;
        if (is_talker) begin
          if (item.opcode == lctar_pkg::OP_TA_HEADER) begin
            cnt <= 5'd0;
            fmt <= hfmt;
            if (hfmt == lctar_pkg::FMT_UNSUPPORTED) begin
              rem  <= {3'b000, hcnt};
              prev <= lctar_pkg::PREV_NONE;
              fmt3 <= 1'b1;
            end else if (hfmt == lctar_pkg::FMT_7BIT) begin
              bpc  <= lctar_pkg::CHAR_7BIT;
              rem  <= h7;
              prev <= (hcnt == 5'd0) ? lctar_pkg::PREV_NONE : op8;
              gath <= hcnt != 5'd0;
              pos  <= 6'd7;
              work <= item.payload << 7;
            end else begin
              // 8-bit characters skip one pad bit after the header fields
              bpc  <= lctar_pkg::CHAR_8BIT;
              rem  <= h8;
              prev <= (hcnt == 5'd0) ? lctar_pkg::PREV_NONE : op8;
              gath <= hcnt != 5'd0;
              pos  <= 6'd8;
              work <= item.payload << 8;
            end
          end else if (in_order) begin
            if ((ctx_cur.rem == 8'd0) || (ctx_cur.bpc == 4'd0)) begin
              prev <= lctar_pkg::PREV_NONE;
            end else begin
              prev <= op8;
              gath <= 1'b1;
            end
          end else begin
            prev <= op8;
          end
        end
      end
      S_GATHER: begin
        if (step) begin
          cnt  <= cnt + 5'd1;
          rem  <= rem - {4'b0000, bpc};
          pos  <= pos + {2'b00, bpc};
          work <= (bpc == lctar_pkg::CHAR_7BIT) ? (work << 7) : (work << 8);
        end
      end
      S_FINISH: begin
        k <= 5'd0;
      end
      S_EMIT: begin
        if (push_free && !k_last) begin
          k <= k + 5'd1;
        end
      end
      default: ;
    endcase
  end

  `ASSERT_IMPLIES(a_store_we_whole_char, clk, rst, store_we, rem >= {4'b0000, bpc}, "store write without a whole character")
  `ASSERT_IMPLIES(a_idle_quiet, clk, rst, in_ready, !store_we && !store_re && !ctx_we, "memory access while idle")
  `ASSERT_NEXT(a_ctx_single_write, clk, rst, ctx_we, !ctx_we, "context written twice for one item")
  `ASSERT_NEXT(a_last_char_idle, clk, rst, push.valid && (push.res.kind == lctar_pkg::KIND_ALIAS) && push.res.last, state == S_IDLE, "emission did not end after last character")

endmodule

// File: design/lc_talker_alias_reassembler.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata (link control block), s_tuser (mode, timeslot)
// m_*       out  m_tvalid/m_tready  m_tdata (call, alias, raw fields), m_tuser, m_tlast
//
// Steps: a short, call or raw item is accepted, its context read and its result pushed; an
// unsupported format also passes the gather and context write-back states. Alias items gather
// up to eight characters, write the context back, and a completing one reads the store once,
// then emits its n characters. The one-port-a-side memories set this sequence.
// Reset clears the sequencer, the context valid bits and the output register; the alias
// store needs no clearing pass. s_tready is high only in idle; m_tready low holds emission.
module lc_talker_alias_reassembler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // block_length[7:0], opcode[13:8], feature_id[21:14], payload[77:22], zero fill[79:78]
  input  logic [lctar_pkg::S_TDATA_W-1:0]  s_tdata,
  // mode[0], timeslot[1]
  input  logic [lctar_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // source_id[23:0], target_id[47:24], alias_char[55:48], alias_format[57:56],
  // raw_opcode[63:58], raw_feature[71:64], raw_payload[127:72]
  output logic [lctar_pkg::M_TDATA_W-1:0]  m_tdata,
  // kind[2:0], ended[3], slot[4]
  output logic [lctar_pkg::M_TUSER_W-1:0]  m_tuser,
  // last result of the item
  output logic                             m_tlast
);

  lctar_pkg::in_item_t in_item;
  lctar_pkg::push_t    push;
  logic                push_free;

  // Unpack the incoming item; the zero fill bits carry nothing
  assign in_item.mode         = s_tuser[0];
  assign in_item.timeslot     = s_tuser[1];
  assign in_item.block_length = s_tdata[7:0];
  assign in_item.opcode       = s_tdata[13:8];
  assign in_item.feature_id   = s_tdata[21:14];
  assign in_item.payload      = s_tdata[77:22];

  // Sequencer: context read-modify-write, character gather, emission
  lctar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .push     (push),
    .push_free(push_free)
  );

  // Output register: holds one result; push_free follows m_tready while it is full
  lctar_outreg u_outreg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_free(push_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
